// ===== rtl/onset_split_peak_and_snr_unit_assert.svh =====
// Assertion macros for the onset split peak and SNR unit.
`ifndef ONSET_SPLIT_PEAK_AND_SNR_UNIT_ASSERT_SVH
`define ONSET_SPLIT_PEAK_AND_SNR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define OSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osp assertion failed");
`define OSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osp assertion failed");
`else
`define OSP_ASSERT_NOW(lbl, ante, cons)
`define OSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/osp_pkg.sv =====
// Shared types and constants of the onset split peak and SNR unit.
package osp_pkg;
  localparam int SAMPLE_W  = 24;
  localparam int PEAK_W    = 24;
  localparam int IDX_W     = 16;
  localparam int RATIO_W   = 39;
  localparam int FRAC_W    = 16;
  localparam int NUM_W     = PEAK_W + FRAC_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(DIV_STEPS - 1);
  localparam logic [IDX_W-1:0]   CNT_LIMIT = {IDX_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
  localparam logic [PEAK_W-1:0]  PEAK_LIM  = {1'b1, {(PEAK_W-1){1'b0}}};

  // one finished record handed from front to back
  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [IDX_W-1:0]  pos;
    logic [PEAK_W-1:0] noise;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;
endpackage

// ===== rtl/onset_split_peak_and_snr_unit.sv =====
// Onset split peak amplitude and SNR unit, top level.
// Throughput: one sample per cycle, held off by in_full only while two finished records wait.
// The record of a last sample passes through the queue into the divider once the back
// end is idle, then through 40 divider steps into the result register.
// A zero noise peak skips the divider and goes from the queue straight to the result.
// Reset (rst_n low, synchronous): onset index 0, record state and queue cleared, no result.
`include "onset_split_peak_and_snr_unit_assert.svh"
module onset_split_peak_and_snr_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [osp_pkg::IDX_W-1:0]           cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [osp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [osp_pkg::PEAK_W-1:0]          out_peak_amplitude,
  output logic [osp_pkg::IDX_W-1:0]           out_peak_position,
  output logic [osp_pkg::RATIO_W-1:0]         out_snr_ratio,
  output logic                                out_noise_zero
);
  logic          q_push, q_full, q_pop, q_empty;
  osp_pkg::rec_t q_din, q_dout;

  assign in_full = q_full;

  osp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  osp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  osp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_dout             (q_dout),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_peak_amplitude (out_peak_amplitude),
    .out_peak_position  (out_peak_position),
    .out_snr_ratio      (out_snr_ratio),
    .out_noise_zero     (out_noise_zero)
  );

  `OSP_ASSERT_NOW(a_nz_sat, !out_empty && out_noise_zero, out_snr_ratio == osp_pkg::RATIO_MAX)
  `OSP_ASSERT_NOW(a_zero_peak, !out_empty && !out_noise_zero && out_peak_amplitude == '0, out_snr_ratio == '0)
  `OSP_ASSERT_NOW(a_peak_lim, !out_empty, out_peak_amplitude <= osp_pkg::PEAK_LIM)
  `OSP_ASSERT_NEXT(a_last_queued, in_push && !in_full && in_last, !q_empty)
endmodule

// ===== rtl/osp_front.sv =====
// Front end: onset register, per-sample peak tracking, record hand-off.
module osp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [osp_pkg::IDX_W-1:0]     cfg_data,
  input  logic                          in_push,
  input  logic signed [osp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_last,
  input  logic                          q_full,
  output logic                          q_push,
  output osp_pkg::rec_t                 q_din
);
  logic [osp_pkg::IDX_W-1:0]  onset_r;
  logic [osp_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [osp_pkg::PEAK_W-1:0] noise_r, noise_nxt;
  logic [osp_pkg::PEAK_W-1:0] sig_r, sig_nxt;
  logic [osp_pkg::IDX_W-1:0]  sidx_r, sidx_nxt;
  logic [osp_pkg::PEAK_W-1:0] mag;
  logic [osp_pkg::PEAK_W-1:0] noise_upd, sig_upd;
  logic [osp_pkg::IDX_W-1:0]  sidx_upd;
  logic                       accept, is_noise;

  assign accept   = in_push && !q_full;
  assign mag      = in_sample[osp_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign is_noise = cnt_r < onset_r;

  always_comb begin
    noise_upd = noise_r;
    sig_upd   = sig_r;
    sidx_upd  = sidx_r;
    if (is_noise) begin
      if (mag > noise_r) noise_upd = mag;
    end else if (mag > sig_r) begin
      sig_upd  = mag;
      sidx_upd = cnt_r;
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    noise_nxt = noise_r;
    sig_nxt   = sig_r;
    sidx_nxt  = sidx_r;
    if (accept) begin
      if (in_last) begin
        cnt_nxt   = '0;
        noise_nxt = '0;
        sig_nxt   = '0;
        sidx_nxt  = '0;
      end else begin
        cnt_nxt   = (cnt_r == osp_pkg::CNT_LIMIT) ? cnt_r : cnt_r + 1'b1;
        noise_nxt = noise_upd;
        sig_nxt   = sig_upd;
        sidx_nxt  = sidx_upd;
      end
    end
  end

  assign q_push      = accept && in_last;
  assign q_din.peak  = sig_upd;
  // no signal sample above zero: position reports the onset
  assign q_din.pos   = (sig_upd == '0) ? onset_r : sidx_upd;
  assign q_din.noise = noise_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onset_r <= '0;
      cnt_r   <= '0;
      noise_r <= '0;
      sig_r   <= '0;
      sidx_r  <= '0;
    end else begin
      if (cfg_we) onset_r <= cfg_data;
      cnt_r   <= cnt_nxt;
      noise_r <= noise_nxt;
      sig_r   <= sig_nxt;
      sidx_r  <= sidx_nxt;
    end
  end
endmodule

// ===== rtl/osp_queue.sv =====
// Two-entry record queue between front and back.
module osp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  osp_pkg::rec_t din,
  output logic          full,
  input  logic          pop,
  output osp_pkg::rec_t dout,
  output logic          empty
);
  osp_pkg::rec_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// ===== rtl/osp_back.sv =====
// Back end: bit-serial restoring divide for the ratio, result register.
module osp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  osp_pkg::rec_t                 q_dout,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [osp_pkg::PEAK_W-1:0]    out_peak_amplitude,
  output logic [osp_pkg::IDX_W-1:0]     out_peak_position,
  output logic [osp_pkg::RATIO_W-1:0]   out_snr_ratio,
  output logic                          out_noise_zero
);
  osp_pkg::back_state_t state_r, state_nxt;
  logic [osp_pkg::NUM_W-1:0]   num_r, num_nxt;   // dividend, then quotient
  logic [osp_pkg::PEAK_W-1:0]  rem_r, rem_nxt;
  logic [osp_pkg::PEAK_W-1:0]  den_r;
  logic [osp_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [osp_pkg::PEAK_W-1:0]  peak_r;
  logic [osp_pkg::IDX_W-1:0]   pos_r;
  logic [osp_pkg::RATIO_W-1:0] ratio_r, ratio_nxt;
  logic                        nz_r, nz_nxt;
  logic [osp_pkg::PEAK_W:0]    trial;
  logic [osp_pkg::PEAK_W-1:0]  diff;
  logic                        qbit, take;

  assign take  = (state_r == osp_pkg::ST_IDLE) && !q_empty;
  assign q_pop = take;
  assign trial = {rem_r, num_r[osp_pkg::NUM_W-1]};
  // difference is below the divisor whenever it is taken, so 24 bits hold it
  assign diff  = trial[osp_pkg::PEAK_W-1:0] - den_r;
  assign qbit  = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    ratio_nxt = ratio_r;
    nz_nxt    = nz_r;
    unique case (state_r)
      osp_pkg::ST_IDLE: begin
        if (take) begin
          num_nxt  = {q_dout.peak, {osp_pkg::FRAC_W{1'b0}}};
          rem_nxt  = '0;
          step_nxt = '0;
          if (q_dout.noise == '0) begin
            ratio_nxt = osp_pkg::RATIO_MAX;
            nz_nxt    = 1'b1;
            state_nxt = osp_pkg::ST_DONE;
          end else begin
            nz_nxt    = 1'b0;
            state_nxt = osp_pkg::ST_DIV;
          end
        end
      end
      osp_pkg::ST_DIV: begin
        rem_nxt  = qbit ? diff : trial[osp_pkg::PEAK_W-1:0];
        num_nxt  = {num_r[osp_pkg::NUM_W-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == osp_pkg::STEP_LAST) begin
          ratio_nxt = num_nxt[osp_pkg::NUM_W-1] ? osp_pkg::RATIO_MAX
                                                : num_nxt[osp_pkg::RATIO_W-1:0];
          state_nxt = osp_pkg::ST_DONE;
        end
      end
      osp_pkg::ST_DONE: begin
        if (out_pop) state_nxt = osp_pkg::ST_IDLE;
      end
      default: state_nxt = osp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    ratio_r <= ratio_nxt;
    nz_r    <= nz_nxt;
    if (take) begin
      den_r  <= q_dout.noise;
      peak_r <= q_dout.peak;
      pos_r  <= q_dout.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= osp_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign out_empty          = state_r != osp_pkg::ST_DONE;
  assign out_peak_amplitude = peak_r;
  assign out_peak_position  = pos_r;
  assign out_snr_ratio      = ratio_r;
  assign out_noise_zero     = nz_r;
endmodule
